FILE: sv/ckw_pkg.sv
// shared types, constants and the cosine table for the cosine delta kernel weight
`default_nettype none
package ckw_pkg;

    // cosine table resolution (samples over [0, pi])
    localparam int COS_TABLE_ENTRIES = 256;
    localparam int IDX_W             = $clog2(COS_TABLE_ENTRIES + 1);

    // fixed-point constants
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam logic [31:0]     INV_WIDTH_RESET = 32'd3276800;

    // datapath widths
    localparam int ABS_W = 33;   // |first - second|
    localparam int MAG_W = 34;   // |r| in Q32.32 while inside the support
    localparam int PHI_W = 30;   // phi in Q30, never above 2^29

    // pipeline stage positions
    localparam int ST_DIFF    = 0;
    localparam int ST_SCALE   = 1;
    localparam int ST_INDEX   = 2;
    localparam int ST_LOOKUP  = 3;
    localparam int ST_INTERP  = 4;
    localparam int ST_PROD    = 5;
    localparam int ST_WIDTH1  = 6;
    localparam int ST_OUT     = 7;
    localparam int NUM_STAGES = 8;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] weight;
        logic        outside_support;
    } t_out_item;

    typedef logic signed [31:0] t_cos_rom [0:COS_TABLE_ENTRIES];

    // cos(pi*k/N) in Q30 from a truncated ten-term series, clamped to [0, 1]
    function automatic longint taylor_cos(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (PI_Q30 * k) / COS_TABLE_ENTRIES;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        // terms of alternating sign, divisor (2n-1)*2n for term n
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd240;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd306;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd380;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        return sum;
    endfunction

    // second half of the table mirrors the first with a sign flip
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        longint   v;
        int       k;
        for (k = 0; k <= COS_TABLE_ENTRIES; k++) begin
            if (2 * k <= COS_TABLE_ENTRIES) begin
                v = taylor_cos(longint'(k));
            end else begin
                v = -taylor_cos(longint'(COS_TABLE_ENTRIES - k));
            end
            rom[k] = v[31:0];
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

endpackage
`default_nettype wire

FILE: sv/ckw_axis_phi.sv
// one axis: distance, scaling, table lookup and interpolation of phi(r)
`default_nettype none
module ckw_axis_phi
    import ckw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_stage_en          i_en,
    input  wire logic [31:0]        i_inv_width,
    input  wire logic signed [31:0] i_first,
    input  wire logic signed [31:0] i_second,
    output logic [PHI_W-1:0]        o_phi,
    output logic                    o_outside
);

    localparam logic [63:0]      TWO_Q32 = 64'h2_0000_0000;
    localparam int               POS_W   = MAG_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(COS_TABLE_ENTRIES);
    localparam logic signed [33:0] MINUS_ONE = -34'sd1073741824;
    localparam logic signed [33:0] ONE       = 34'sd1073741824;

    // stage registers
    logic [ABS_W-1:0]   r_abs;
    logic [63:0]        r_mag;
    logic               r_out_idx, r_out_lookup, r_out_interp;
    logic [IDX_W-1:0]   r_idx;
    logic [15:0]        r_frac_idx, r_frac_lookup;
    logic signed [31:0] r_c0;
    logic [31:0]        r_dmag;
    logic               r_neg;
    logic [PHI_W-1:0]   r_phi;

    logic signed [32:0] n_diff;
    logic [ABS_W-1:0]   n_abs;
    logic [POS_W-1:0]   n_pos2;
    logic [IDX_W-1:0]   n_idx_lo, n_idx_hi;
    logic signed [32:0] n_cdiff;
    logic [47:0]        n_step_full;
    logic signed [33:0] n_c;
    logic signed [33:0] n_sum;

    // absolute coordinate difference
    always_comb begin
        n_diff = {i_first[31], i_first} - {i_second[31], i_second};
        n_abs  = n_diff[32] ? (ABS_W'(0) - ABS_W'(n_diff)) : ABS_W'(n_diff);
    end

    // table position times two: |r| * N, low bit dropped below
    assign n_pos2 = {{IDX_W{1'b0}}, r_mag[MAG_W-1:0]} * POS_W'(COS_TABLE_ENTRIES);

    // neighbor entries, clamped at the table end
    always_comb begin
        if (r_idx >= LAST) begin
            n_idx_lo = LAST;
            n_idx_hi = LAST;
        end else begin
            n_idx_lo = r_idx;
            n_idx_hi = r_idx + IDX_W'(1);
        end
        n_cdiff = {COS_ROM[n_idx_hi][31], COS_ROM[n_idx_hi]}
                - {COS_ROM[n_idx_lo][31], COS_ROM[n_idx_lo]};
    end

    // interpolation step on the magnitude, then phi = (1 + cos) / 4
    always_comb begin
        n_step_full = {16'd0, r_dmag} * {32'd0, r_frac_lookup};
        if (r_neg) begin
            n_c = {{2{r_c0[31]}}, r_c0} - {2'b00, n_step_full[47:16]};
        end else begin
            n_c = {{2{r_c0[31]}}, r_c0} + {2'b00, n_step_full[47:16]};
        end
        if (n_c < MINUS_ONE) begin
            n_c = MINUS_ONE;
        end
        n_sum = n_c + ONE;
    end

    // pipeline registers, each stage loads on its own enable
    always_ff @(posedge i_clk) begin
        if (i_en[ST_DIFF]) begin
            r_abs <= n_abs;
        end
        if (i_en[ST_SCALE]) begin
            r_mag <= {31'd0, r_abs} * {32'd0, i_inv_width};
        end
        if (i_en[ST_INDEX]) begin
            r_out_idx  <= (r_mag > TWO_Q32);
            r_idx      <= n_pos2[33 +: IDX_W];
            r_frac_idx <= n_pos2[32:17];
        end
        if (i_en[ST_LOOKUP]) begin
            r_out_lookup  <= r_out_idx;
            r_frac_lookup <= r_frac_idx;
            r_c0          <= COS_ROM[n_idx_lo];
            r_neg         <= n_cdiff[32];
            r_dmag        <= n_cdiff[32] ? 32'(33'sd0 - n_cdiff) : n_cdiff[31:0];
        end
        if (i_en[ST_INTERP]) begin
            r_out_interp <= r_out_lookup;
            r_phi        <= n_sum[31:2];
        end
    end

    assign o_phi     = r_phi;
    assign o_outside = r_out_interp;

endmodule
`default_nettype wire

FILE: sv/ckw_weight.sv
// product of the two phi values scaled twice by the reciprocal width, saturated
`default_nettype none
module ckw_weight
    import ckw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_stage_en        i_en,
    input  wire logic [31:0]      i_inv_width,
    input  wire logic [PHI_W-1:0] i_phi_x,
    input  wire logic [PHI_W-1:0] i_phi_y,
    input  wire logic             i_outside_x,
    input  wire logic             i_outside_y,
    output t_out_item             o_result
);

    logic [PHI_W-1:0] r_m;
    logic [45:0]      r_s;
    logic             r_out_prod, r_out_width1;
    t_out_item        r_result;

    logic [2*PHI_W-1:0] n_m_full;
    logic [61:0]        n_s_full;
    logic [63:0]        n_w_full;
    logic [31:0]        n_weight;

    // products between registers, one multiplier per stage
    always_comb begin
        n_m_full = i_phi_x * i_phi_y;
        n_s_full = {32'd0, r_m} * {30'd0, i_inv_width};
        n_w_full = {32'd0, r_s[45:14]} * {32'd0, i_inv_width};
        if (|n_w_full[63:48]) begin
            n_weight = '1;
        end else begin
            n_weight = n_w_full[47:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_PROD]) begin
            r_m        <= n_m_full[2*PHI_W-1:30];
            r_out_prod <= i_outside_x | i_outside_y;
        end
        if (i_en[ST_WIDTH1]) begin
            r_s          <= n_s_full[61:16];
            r_out_width1 <= r_out_prod;
        end
        if (i_en[ST_OUT]) begin
            r_result.weight          <= r_out_width1 ? 32'd0 : n_weight;
            r_result.outside_support <= r_out_width1;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

FILE: sv/cosine_delta_kernel_weight.sv
// top level of the cosine delta kernel weight pipeline
`default_nettype none
// Cosine delta kernel weight: for a pair of 2D points in signed Q16.16 it returns
// (1/h)^2 * phi(rx) * phi(ry) in unsigned Q16.16, saturated, with a flag when either
// scaled axis distance exceeds two (weight then zero). The datapath is an 8-stage
// pipeline with at most one multiplier or one table lookup per stage; it takes one
// pair per clock while o_in_stall is low. A result leaves ST_OUT when the output is
// not stalled. A stall only holds the stages that are full, so bubbles close up and
// new transactions keep entering while a result waits, until every stage is full.
// inv_width resets to 50.0 and is written through i_cfg_wr_en/i_cfg_wr_data;
// the user must write it only while the pipeline is empty; the block does not check.
module cosine_delta_kernel_weight
    import ckw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data
);

    logic [31:0]     r_inv_width;
    t_stage_en       r_valid;
    t_stage_en       n_en;
    logic [PHI_W-1:0] phi_x, phi_y;
    logic            outside_x, outside_y;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_width <= INV_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_inv_width <= i_cfg_wr_data;
        end
    end

    // a stage loads when it is empty or the next stage loads
    always_comb begin
        n_en[ST_OUT] = !r_valid[ST_OUT] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_valid[k] || n_en[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_en[ST_DIFF]) begin
                r_valid[ST_DIFF] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // per-axis phi pipelines
    ckw_axis_phi u_axis_x (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_inv_width (r_inv_width),
        .i_first     (i_in_data.first_x),
        .i_second    (i_in_data.second_x),
        .o_phi       (phi_x),
        .o_outside   (outside_x)
    );

    ckw_axis_phi u_axis_y (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_inv_width (r_inv_width),
        .i_first     (i_in_data.first_y),
        .i_second    (i_in_data.second_y),
        .o_phi       (phi_y),
        .o_outside   (outside_y)
    );

    // combine the axes and scale
    ckw_weight u_weight (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_inv_width (r_inv_width),
        .i_phi_x     (phi_x),
        .i_phi_y     (phi_y),
        .i_outside_x (outside_x),
        .i_outside_y (outside_y),
        .o_result    (o_out_data)
    );

    assign o_in_stall  = !n_en[ST_DIFF];
    assign o_out_valid = r_valid[ST_OUT];

`ifndef SYNTHESIS
    // a result flagged outside the support carries zero weight
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.outside_support |-> o_out_data.weight == 32'd0)
        else $error("outside support with nonzero weight");

    // full pipeline with a stalled output takes nothing in
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) && i_out_stall |-> o_in_stall)
        else $error("transaction accepted into a full stalled pipeline");

    // an accepted transaction occupies the first stage next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_valid[ST_DIFF])
        else $error("accepted transaction lost at pipeline entry");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_cosine_delta_kernel_weight.sv
// self-checking testbench for the cosine delta kernel weight pipeline
module tb_cosine_delta_kernel_weight;
    import ckw_pkg::*;

    // predictor constants
    localparam longint          UNIT_Q30     = 64'sd1073741824;
    localparam longint unsigned ANGLE_PI_Q30 = 64'd3373259426;
    localparam longint unsigned SLOTS        = COS_TABLE_ENTRIES;
    localparam logic [31:0]     W_ONE        = 32'h0001_0000;
    localparam int              HOLD_CYCLES  = 80;
    localparam int              LIMIT_CYCLES = 100000;

    typedef struct {
        logic [31:0] width;
        t_in_item    pair;
        bit          typed;
        t_out_item   want;
    } t_probe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    longint      cos_q30 [0:COS_TABLE_ENTRIES];
    t_out_item   weights_due [$];
    logic [31:0] width_now = INV_WIDTH_RESET;
    int          mismatches = 0;
    int          send_idle_pct = 21;
    int          recv_stall_pct = 68;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          cycle_count = 0;

    // directed transactions: extremes, exactly at two, table end, zero width, saturation
    t_probe probes [21] = '{
        '{INV_WIDTH_RESET, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, {32'd40960000, 1'b0}},
        '{INV_WIDTH_RESET, {32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0}, 1'b1,
          {32'd0, 1'b1}},
        '{INV_WIDTH_RESET, {32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF}, 1'b1,
          {32'd0, 1'b1}},
        '{INV_WIDTH_RESET, {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
          1'b1, {32'd40960000, 1'b0}},
        '{INV_WIDTH_RESET, {32'h0000_0400, 32'h0, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{INV_WIDTH_RESET, {32'h0, 32'h0, 32'h0, 32'h0000_0A00}, 1'b0, {32'd0, 1'b0}},
        '{INV_WIDTH_RESET, {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{W_ONE, {32'h0002_0000, 32'h0, 32'h0, 32'h0}, 1'b1, {32'd0, 1'b0}},
        '{W_ONE, {32'h0, 32'h0, 32'h0002_0000, 32'h0}, 1'b1, {32'd0, 1'b0}},
        '{W_ONE, {32'h0002_0001, 32'h0, 32'h0, 32'h0}, 1'b1, {32'd0, 1'b1}},
        '{W_ONE, {32'h0, 32'hFFFE_0000, 32'h0, 32'h0}, 1'b1, {32'd0, 1'b0}},
        '{W_ONE, {32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{W_ONE, {32'h0001_FFFF, 32'h0, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{32'h0, {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
          {32'd0, 1'b0}},
        '{32'h0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1, {32'd0, 1'b0}},
        '{32'hFFFF_FFFF, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, {32'hFFFF_FFFF, 1'b0}},
        '{32'hFFFF_FFFF, {32'h1, 32'h0, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{32'hFFFF_FFFF, {32'h0, 32'h2, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{32'hFFFF_FFFF, {32'h3, 32'h0, 32'h0, 32'h0}, 1'b1, {32'd0, 1'b1}},
        '{32'h1, {32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0}, 1'b0, {32'd0, 1'b0}},
        '{32'h1, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, {32'd0, 1'b0}}
    };

    cosine_delta_kernel_weight dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cos(pi*k/N) in Q30 from a truncated ten-term series, clamped to [0, 1]
    function automatic longint series_cos(input longint unsigned k);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint          total;
        int              n;
        angle    = (ANGLE_PI_Q30 * k) / SLOTS;
        angle_sq = (angle * angle) >> 30;
        term     = UNIT_Q30;
        total    = UNIT_Q30;
        for (n = 1; n <= 10; n++) begin
            term = ((term * angle_sq) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                total = total - signed'(term);
            end else begin
                total = total + signed'(term);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        if (total > UNIT_Q30) begin
            total = UNIT_Q30;
        end
        return total;
    endfunction

    // phi of one axis in Q30, flags a scaled distance beyond two
    function automatic longint unsigned axis_phi(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [31:0] w, output bit far);
        longint          d;
        longint          c;
        longint          slope;
        longint unsigned span;
        longint unsigned mag;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        d    = longint'(a) - longint'(b);
        span = (d < 0) ? -d : d;
        mag  = span * w;
        far  = 1'b0;
        if (mag > (64'd2 << 32)) begin
            far = 1'b1;
            return 0;
        end
        pos = (mag * SLOTS) >> 1;
        idx = pos >> 32;
        if (idx >= SLOTS) begin
            c = cos_q30[COS_TABLE_ENTRIES];
        end else begin
            frac  = (pos & 64'hFFFF_FFFF) >> 16;
            c     = cos_q30[idx];
            slope = cos_q30[idx + 1] - c;
            // linear interpolation, step truncated toward zero
            if (slope >= 0) begin
                c = c + signed'((unsigned'(slope) * frac) >> 16);
            end else begin
                c = c - signed'((unsigned'(-slope) * frac) >> 16);
            end
        end
        if (c < -UNIT_Q30) begin
            c = -UNIT_Q30;
        end
        return unsigned'(UNIT_Q30 + c) >> 2;
    endfunction

    // expected weight and support flag for one pair of points
    function automatic t_out_item kernel_weight(input t_in_item p, input logic [31:0] w);
        t_out_item       r;
        bit              far_x;
        bit              far_y;
        longint unsigned px;
        longint unsigned py;
        longint unsigned m;
        longint unsigned s;
        longint unsigned v;
        px = axis_phi(p.first_x, p.second_x, w, far_x);
        py = axis_phi(p.first_y, p.second_y, w, far_y);
        r.weight          = '0;
        r.outside_support = far_x | far_y;
        if (!r.outside_support) begin
            m = (px * py) >> 30;
            s = (m * w) >> 16;
            v = ((s >> 14) * w) >> 16;
            r.weight = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
        return r;
    endfunction

    // mostly pairs near each other so the support is reached, some unrelated pairs
    function automatic t_in_item random_pair(input logic [31:0] w);
        t_in_item        p;
        longint unsigned reach;
        logic [31:0]     dx;
        logic [31:0]     dy;
        p.first_x = $urandom();
        p.first_y = $urandom();
        if ($urandom_range(9, 0) < 2) begin
            p.second_x = $urandom();
            p.second_y = $urandom();
        end else begin
            reach = (w == 0) ? 64'hFFFF_FFFF : 64'd10737418240 / w;
            if (reach > 64'hFFFF_FFFF) begin
                reach = 64'hFFFF_FFFF;
            end
            dx = $urandom_range(reach[31:0], 0);
            dy = $urandom_range(reach[31:0], 0);
            p.second_x = $urandom_range(1, 0) ? p.first_x - dx : p.first_x + dx;
            p.second_y = $urandom_range(1, 0) ? p.first_y - dy : p.first_y + dy;
        end
        return p;
    endfunction

    // offer one transaction, record its expected result once accepted
    task automatic offer_pair(input t_in_item pair, input t_out_item want);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pair;
        do @(posedge i_clk); while (o_in_stall);
        weights_due = {weights_due, want};
        @(negedge i_clk);
    endtask

    // sender pauses until the pipeline is empty, then writes the width
    task automatic switch_phase(input logic [31:0] w, input int s_pct, input int r_pct,
                                input bit hold);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (weights_due.size() != 0);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (hold) begin
            hold_requests++;
        end
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_now = w;
    endtask

    // receiver stall: random, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (weights_due.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual %h/%b", $time,
                         o_out_data.weight, o_out_data.outside_support);
                mismatches++;
            end else begin
                due = weights_due.pop_front();
                if (o_out_data.weight !== due.weight) begin
                    $display("%0t weight mismatch: expected %h, actual %h", $time,
                             due.weight, o_out_data.weight);
                    mismatches++;
                end
                if (o_out_data.outside_support !== due.outside_support) begin
                    $display("%0t outside_support mismatch: expected %b, actual %b", $time,
                             due.outside_support, o_out_data.outside_support);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_cosine_delta_kernel_weight failed");
            $finish;
        end
    end

    initial begin
        int          k;
        int          seg;
        int          i;
        int          phase;
        t_in_item    pair;
        logic [31:0] w;
        for (k = 0; k <= COS_TABLE_ENTRIES; k++) begin
            cos_q30[k] = (2 * k <= COS_TABLE_ENTRIES) ? series_cos(k)
                                                      : -series_cos(COS_TABLE_ENTRIES - k);
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (probes[r]) begin
            if (probes[r].width != width_now) begin
                switch_phase(probes[r].width, 21, 68, 1'b0);
            end
            offer_pair(probes[r].pair, probes[r].typed ? probes[r].want
                                                       : kernel_weight(probes[r].pair,
                                                                       width_now));
        end

        // random segments, a new width each, idling pattern changes every three
        for (seg = 0; seg < 9; seg++) begin
            case ($urandom_range(6, 0))
                0:       w = INV_WIDTH_RESET;
                1:       w = W_ONE;
                2:       w = $urandom_range(32'h0100_0000, 1);
                3:       w = $urandom();
                4:       w = 32'hFFFF_FFFF;
                5:       w = $urandom_range(16, 0);
                default: w = $urandom_range(32'h0400_0000, 32'h0001_0000);
            endcase
            phase = seg / 3;
            // one long receiver hold-off while the sender keeps offering
            case (phase)
                0:       switch_phase(w, 21, 68, seg == 1);
                1:       switch_phase(w, 68, 21, 1'b0);
                default: switch_phase(w, 0, 0, 1'b0);
            endcase
            for (i = 0; i < 44; i++) begin
                pair = random_pair(width_now);
                offer_pair(pair, kernel_weight(pair, width_now));
            end
        end

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_STAGES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_cosine_delta_kernel_weight passed");
        end else begin
            $display("tb_cosine_delta_kernel_weight failed");
        end
        $finish;
    end

endmodule
